### hw/rtl/adaptive_kalman_filter_step_defines.svh
// ----------------------------------------------------------------------------
// Adaptive Kalman filter step: assertion macros
// Shared concurrent assertion forms, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ADAPTIVE_KALMAN_FILTER_STEP_DEFINES_SVH
`define ADAPTIVE_KALMAN_FILTER_STEP_DEFINES_SVH
`ifndef SYNTH
`define AKF_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("akf assertion failed");
`define AKF_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("akf assertion failed");
`else
`define AKF_ASSERT_IMP(label, ante, cons)
`define AKF_ASSERT_NXT(label, ante, cons)
`endif
`endif

### hw/rtl/akf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Adaptive Kalman filter step: package
// Control word layout, source codes, saturation helper and the microprogram.
// ----------------------------------------------------------------------------
package akf_pkg;

    localparam int unsigned NUM_REGS = 6;
    localparam int unsigned PC_W     = 6;
    localparam int unsigned SRC_W    = 6;
    localparam int unsigned ADDR_W   = 5;
    localparam int unsigned DIVD_W   = 64;
    localparam int unsigned DIVS_W   = 33;

    localparam logic [2:0] CFG_F_ROW0 = 3'd0;
    localparam logic [2:0] CFG_F_ROW1 = 3'd1;
    localparam logic [2:0] CFG_Q_ROW0 = 3'd2;
    localparam logic [2:0] CFG_Q_ROW1 = 3'd3;
    localparam logic [2:0] CFG_H_ROW  = 3'd4;
    localparam logic [2:0] CFG_INIT   = 3'd5;

    localparam logic [63:0] F_ROW0_RESET = 64'h0000_0000_0001_0000;
    localparam logic [63:0] F_ROW1_RESET = 64'h0001_0000_0000_0000;
    localparam logic [31:0] ONE_Q16      = 32'h0001_0000;

    // Micro-operations.
    localparam logic [2:0] OP_ARITH = 3'd0;
    localparam logic [2:0] OP_MEAN  = 3'd1;
    localparam logic [2:0] OP_RECIP = 3'd2;
    localparam logic [2:0] OP_JUMP  = 3'd3;
    localparam logic [2:0] OP_DONE  = 3'd4;

    localparam logic COND_RESTART = 1'b0;
    localparam logic COND_NOTPOS  = 1'b1;

    localparam logic [1:0] CNT_KEEP  = 2'd0;
    localparam logic [1:0] CNT_INC   = 2'd1;
    localparam logic [1:0] CNT_CLEAR = 2'd2;

    // Scratch memory words (codes below 32) and external sources (32 and up).
    localparam logic [5:0] M_X0    = 6'd0;
    localparam logic [5:0] M_X1    = 6'd1;
    localparam logic [5:0] M_P00   = 6'd2;
    localparam logic [5:0] M_P01   = 6'd3;
    localparam logic [5:0] M_P10   = 6'd4;
    localparam logic [5:0] M_P11   = 6'd5;
    localparam logic [5:0] M_CM    = 6'd6;
    localparam logic [5:0] M_XP0   = 6'd7;
    localparam logic [5:0] M_XP1   = 6'd8;
    localparam logic [5:0] M_FP00  = 6'd9;
    localparam logic [5:0] M_FP01  = 6'd10;
    localparam logic [5:0] M_FP10  = 6'd11;
    localparam logic [5:0] M_FP11  = 6'd12;
    localparam logic [5:0] M_PA00  = 6'd13;
    localparam logic [5:0] M_PA01  = 6'd14;
    localparam logic [5:0] M_PA10  = 6'd15;
    localparam logic [5:0] M_PA11  = 6'd16;
    localparam logic [5:0] M_V     = 6'd17;
    localparam logic [5:0] M_VV    = 6'd18;
    localparam logic [5:0] M_PHT0  = 6'd19;
    localparam logic [5:0] M_PHT1  = 6'd20;
    localparam logic [5:0] M_HPH   = 6'd21;
    localparam logic [5:0] M_R     = 6'd22;
    localparam logic [5:0] M_S     = 6'd23;
    localparam logic [5:0] M_INV   = 6'd24;
    localparam logic [5:0] M_K0    = 6'd25;
    localparam logic [5:0] M_K1    = 6'd26;
    localparam logic [5:0] M_IKH00 = 6'd27;
    localparam logic [5:0] M_IKH01 = 6'd28;
    localparam logic [5:0] M_IKH10 = 6'd29;
    localparam logic [5:0] M_IKH11 = 6'd30;

    localparam logic [5:0] SRC_F00  = 6'd32;
    localparam logic [5:0] SRC_F01  = 6'd33;
    localparam logic [5:0] SRC_F10  = 6'd34;
    localparam logic [5:0] SRC_F11  = 6'd35;
    localparam logic [5:0] SRC_Q00  = 6'd36;
    localparam logic [5:0] SRC_Q01  = 6'd37;
    localparam logic [5:0] SRC_Q10  = 6'd38;
    localparam logic [5:0] SRC_Q11  = 6'd39;
    localparam logic [5:0] SRC_H0   = 6'd40;
    localparam logic [5:0] SRC_H1   = 6'd41;
    localparam logic [5:0] SRC_I0   = 6'd42;
    localparam logic [5:0] SRC_I1   = 6'd43;
    localparam logic [5:0] SRC_Z    = 6'd44;
    localparam logic [5:0] SRC_ONE  = 6'd45;
    localparam logic [5:0] SRC_ZERO = 6'd46;

    localparam logic [5:0] PC_SING = 6'd34;
    localparam logic [5:0] PC_RST  = 6'd37;

    typedef struct packed {
        logic [2:0] op;
        logic       cond;
        logic [1:0] cnt;
        logic       sub;
        logic       clamp;
        logic [5:0] a;
        logic [5:0] b;
        logic [5:0] c;
        logic [5:0] d;
        logic [5:0] e;
        logic [4:0] dest;
        logic [5:0] target;
    } ctl_t;

    typedef struct packed {
        logic               clip;
        logic signed [31:0] val;
    } sat_t;

    function automatic sat_t sat32(input logic signed [50:0] v);
        sat_t r;
        if (v[50:31] == {20{v[31]}}) begin
            r.clip = 1'b0;
            r.val  = v[31:0];
        end else begin
            r.clip = 1'b1;
            r.val  = v[50] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        return r;
    endfunction

    // y = sat(e +/- sat(round(a*b + c*d)))
    function automatic ctl_t u_ar(input logic [5:0] e, input logic [5:0] a,
                                  input logic [5:0] b, input logic [5:0] c,
                                  input logic [5:0] d, input logic sub,
                                  input logic clamp, input logic [5:0] dest);
        ctl_t w;
        w       = '0;
        w.op    = OP_ARITH;
        w.e     = e;
        w.a     = a;
        w.b     = b;
        w.c     = c;
        w.d     = d;
        w.sub   = sub;
        w.clamp = clamp;
        w.dest  = dest[4:0];
        return w;
    endfunction

    function automatic ctl_t u_div(input logic [2:0] op, input logic [5:0] a,
                                   input logic [5:0] b, input logic [5:0] dest);
        ctl_t w;
        w      = '0;
        w.op   = op;
        w.a    = a;
        w.b    = b;
        w.dest = dest[4:0];
        return w;
    endfunction

    function automatic ctl_t u_jump(input logic cond, input logic [5:0] a,
                                    input logic [5:0] target);
        ctl_t w;
        w        = '0;
        w.op     = OP_JUMP;
        w.cond   = cond;
        w.a      = a;
        w.target = target;
        return w;
    endfunction

    function automatic ctl_t u_done(input logic [1:0] cnt);
        ctl_t w;
        w     = '0;
        w.op  = OP_DONE;
        w.cnt = cnt;
        return w;
    endfunction

    function automatic ctl_t ucode(input logic [5:0] pc);
        ctl_t w;
        case (pc)
            6'd0:  w = u_jump(COND_RESTART, SRC_ZERO, PC_RST);
            // Predict.
            6'd1:  w = u_ar(SRC_ZERO, SRC_F00, M_X0, SRC_F01, M_X1, 1'b0, 1'b0, M_XP0);
            6'd2:  w = u_ar(SRC_ZERO, SRC_F10, M_X0, SRC_F11, M_X1, 1'b0, 1'b0, M_XP1);
            6'd3:  w = u_ar(SRC_ZERO, SRC_F00, M_P00, SRC_F01, M_P10, 1'b0, 1'b0, M_FP00);
            6'd4:  w = u_ar(SRC_ZERO, SRC_F00, M_P01, SRC_F01, M_P11, 1'b0, 1'b0, M_FP01);
            6'd5:  w = u_ar(SRC_ZERO, SRC_F10, M_P00, SRC_F11, M_P10, 1'b0, 1'b0, M_FP10);
            6'd6:  w = u_ar(SRC_ZERO, SRC_F10, M_P01, SRC_F11, M_P11, 1'b0, 1'b0, M_FP11);
            6'd7:  w = u_ar(SRC_Q00, M_FP00, SRC_F00, M_FP01, SRC_F01, 1'b0, 1'b0, M_PA00);
            6'd8:  w = u_ar(SRC_Q01, M_FP00, SRC_F10, M_FP01, SRC_F11, 1'b0, 1'b0, M_PA01);
            6'd9:  w = u_ar(SRC_Q10, M_FP10, SRC_F00, M_FP11, SRC_F01, 1'b0, 1'b0, M_PA10);
            6'd10: w = u_ar(SRC_Q11, M_FP10, SRC_F10, M_FP11, SRC_F11, 1'b0, 1'b0, M_PA11);
            // Innovation and its running mean square.
            6'd11: w = u_ar(SRC_Z, SRC_H0, M_XP0, SRC_H1, M_XP1, 1'b1, 1'b0, M_V);
            6'd12: w = u_ar(SRC_ZERO, M_V, M_V, SRC_ZERO, SRC_ZERO, 1'b0, 1'b0, M_VV);
            6'd13: w = u_div(OP_MEAN, M_CM, M_VV, M_CM);
            // Adapted noise and innovation variance.
            6'd14: w = u_ar(SRC_ZERO, M_PA00, SRC_H0, M_PA01, SRC_H1, 1'b0, 1'b0, M_PHT0);
            6'd15: w = u_ar(SRC_ZERO, M_PA10, SRC_H0, M_PA11, SRC_H1, 1'b0, 1'b0, M_PHT1);
            6'd16: w = u_ar(SRC_ZERO, SRC_H0, M_PHT0, SRC_H1, M_PHT1, 1'b0, 1'b0, M_HPH);
            6'd17: w = u_ar(M_CM, M_HPH, SRC_ONE, SRC_ZERO, SRC_ZERO, 1'b1, 1'b1, M_R);
            6'd18: w = u_ar(M_R, M_HPH, SRC_ONE, SRC_ZERO, SRC_ZERO, 1'b0, 1'b0, M_S);
            6'd19: w = u_jump(COND_NOTPOS, M_S, PC_SING);
            // Gain and update.
            6'd20: w = u_div(OP_RECIP, M_S, SRC_ZERO, M_INV);
            6'd21: w = u_ar(SRC_ZERO, M_PHT0, M_INV, SRC_ZERO, SRC_ZERO, 1'b0, 1'b0, M_K0);
            6'd22: w = u_ar(SRC_ZERO, M_PHT1, M_INV, SRC_ZERO, SRC_ZERO, 1'b0, 1'b0, M_K1);
            6'd23: w = u_ar(M_XP0, M_K0, M_V, SRC_ZERO, SRC_ZERO, 1'b0, 1'b0, M_X0);
            6'd24: w = u_ar(M_XP1, M_K1, M_V, SRC_ZERO, SRC_ZERO, 1'b0, 1'b0, M_X1);
            6'd25: w = u_ar(SRC_ONE, M_K0, SRC_H0, SRC_ZERO, SRC_ZERO, 1'b1, 1'b0, M_IKH00);
            6'd26: w = u_ar(SRC_ZERO, M_K0, SRC_H1, SRC_ZERO, SRC_ZERO, 1'b1, 1'b0, M_IKH01);
            6'd27: w = u_ar(SRC_ZERO, M_K1, SRC_H0, SRC_ZERO, SRC_ZERO, 1'b1, 1'b0, M_IKH10);
            6'd28: w = u_ar(SRC_ONE, M_K1, SRC_H1, SRC_ZERO, SRC_ZERO, 1'b1, 1'b0, M_IKH11);
            6'd29: w = u_ar(SRC_ZERO, M_IKH00, M_PA00, M_IKH01, M_PA10, 1'b0, 1'b0, M_P00);
            6'd30: w = u_ar(SRC_ZERO, M_IKH00, M_PA01, M_IKH01, M_PA11, 1'b0, 1'b0, M_P01);
            6'd31: w = u_ar(SRC_ZERO, M_IKH10, M_PA00, M_IKH11, M_PA10, 1'b0, 1'b0, M_P10);
            6'd32: w = u_ar(SRC_ZERO, M_IKH10, M_PA01, M_IKH11, M_PA11, 1'b0, 1'b0, M_P11);
            6'd33: w = u_done(CNT_INC);
            // Singular: re-issue the unchanged estimate to the result.
            6'd34: w = u_ar(SRC_ZERO, M_X0, SRC_ONE, SRC_ZERO, SRC_ZERO, 1'b0, 1'b0, M_X0);
            6'd35: w = u_ar(SRC_ZERO, M_X1, SRC_ONE, SRC_ZERO, SRC_ZERO, 1'b0, 1'b0, M_X1);
            6'd36: w = u_done(CNT_KEEP);
            // Restart: load the initial estimate.
            6'd37: w = u_ar(SRC_ZERO, SRC_I0, SRC_ONE, SRC_ZERO, SRC_ZERO, 1'b0, 1'b0, M_X0);
            6'd38: w = u_ar(SRC_ZERO, SRC_I1, SRC_ONE, SRC_ZERO, SRC_ZERO, 1'b0, 1'b0, M_X1);
            6'd39: w = u_done(CNT_CLEAR);
            default: w = u_done(CNT_KEEP);
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

### hw/rtl/akf_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Adaptive Kalman filter step: unsigned divider
// Restoring radix-2 division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module akf_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [akf_pkg::DIVD_W-1:0]  dividend,
    input  logic [akf_pkg::DIVS_W-1:0]  divisor,
    output logic                        busy,
    output logic                        done,
    output logic [akf_pkg::DIVD_W-1:0]  quotient
);

    localparam int unsigned CNT_W = $clog2(akf_pkg::DIVD_W);

    logic                       busy_reg;
    logic                       done_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic [akf_pkg::DIVS_W-1:0] rem_reg;
    logic [akf_pkg::DIVS_W-1:0] dsr_reg;
    logic [akf_pkg::DIVD_W-1:0] quo_reg;

    logic [akf_pkg::DIVS_W:0]   shifted;
    logic                       ge;
    logic [akf_pkg::DIVS_W:0]   diff;

    assign shifted = {rem_reg, quo_reg[akf_pkg::DIVD_W-1]};
    assign diff    = shifted - {1'b0, dsr_reg};
    assign ge      = (shifted >= {1'b0, dsr_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(akf_pkg::DIVD_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            dsr_reg <= divisor;
            quo_reg <= dividend;
        end else if (busy_reg) begin
            rem_reg <= ge ? diff[akf_pkg::DIVS_W-1:0] : shifted[akf_pkg::DIVS_W-1:0];
            quo_reg <= {quo_reg[akf_pkg::DIVD_W-2:0], ge};
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire

### hw/rtl/adaptive_kalman_filter_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Adaptive Kalman filter step
// Two-state filter with one scalar measurement and innovation-based noise
// adaptation, run by a microprogram over one shared multiply-accumulate path.
// ----------------------------------------------------------------------------
//  channel  | ports                       | meaning
//  s_       | measurement, restart        | one measurement or a restart item
//  m_       | estimate, innovation, flags | one result item per input item
//  cfg_     | cfg_index, cfg_data         | 64-bit register writes, always ready
//
//  A measurement item runs 29 arithmetic steps on the single 33x33 multiplier,
//  two divisions (mean square update and gain reciprocal), two jumps and the
//  final step. A singular item and a restart item run shorter programs.
//  A synchronous reset returns the registers to their defaults and the state to zero.
//  A finished item waits in the output register; the next item is taken as
//  soon as the program has ended, even while that result is still pending.
// ----------------------------------------------------------------------------
`include "adaptive_kalman_filter_step_defines.svh"

module adaptive_kalman_filter_step (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_measurement,
    input  logic               s_restart,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_estimate_first,
    output logic signed [31:0] m_estimate_second,
    output logic signed [31:0] m_innovation,
    output logic [30:0]        m_noise_estimate,
    output logic               m_singular,
    output logic               m_saturated,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [63:0]        cfg_data
);

    localparam logic [2:0] PH0 = 3'd0;
    localparam logic [2:0] PH1 = 3'd1;
    localparam logic [2:0] PH2 = 3'd2;
    localparam logic [2:0] PH3 = 3'd3;
    localparam logic [2:0] PH4 = 3'd4;
    localparam logic [2:0] PH5 = 3'd5;

    localparam int unsigned DEPTH = 2 ** akf_pkg::ADDR_W;

    logic [63:0]                 cfg_reg [akf_pkg::NUM_REGS];
    logic                        busy_reg;
    logic [akf_pkg::PC_W-1:0]    pc_reg;
    logic [2:0]                  ph_reg;
    logic                        restart_reg;
    logic [31:0]                 z_reg;
    logic [31:0]                 count_reg;
    logic                        m_valid_reg;
    logic [DEPTH-1:0]            vld_reg;

    logic [31:0]                 mem [DEPTH];
    logic [31:0]                 mem_qa_reg;
    logic [31:0]                 mem_qb_reg;
    logic                        vld_qa_reg;
    logic                        vld_qb_reg;
    logic                        sel_qa_reg;
    logic                        sel_qb_reg;
    logic [31:0]                 ext_qa_reg;
    logic [31:0]                 ext_qb_reg;

    logic signed [65:0]          prod_reg;
    logic signed [66:0]          acc_reg;
    logic signed [31:0]          e_reg;
    logic signed [31:0]          t_reg;

    logic signed [31:0]          wk_est0_reg;
    logic signed [31:0]          wk_est1_reg;
    logic signed [31:0]          wk_innov_reg;
    logic [30:0]                 wk_noise_reg;
    logic                        wk_sing_reg;
    logic                        clip_reg;

    logic signed [31:0]          out_est0_reg;
    logic signed [31:0]          out_est1_reg;
    logic signed [31:0]          out_innov_reg;
    logic [30:0]                 out_noise_reg;
    logic                        out_sing_reg;
    logic                        out_sat_reg;

    akf_pkg::ctl_t               ctl;
    logic [akf_pkg::SRC_W-1:0]   src_a;
    logic [akf_pkg::SRC_W-1:0]   src_b;
    logic signed [31:0]          opa;
    logic signed [31:0]          opb;
    logic signed [32:0]          mul_a;
    logic signed [32:0]          mul_b;
    logic signed [66:0]          round_sum;
    akf_pkg::sat_t               t_sat;
    logic signed [33:0]          sum34;
    akf_pkg::sat_t               y_sat;
    logic signed [31:0]          y_val;
    logic [32:0]                 cnt_p1;
    logic [akf_pkg::DIVD_W-1:0]  div_dividend;
    logic [akf_pkg::DIVS_W-1:0]  div_divisor;
    logic                        div_start;
    logic                        div_busy;
    logic                        div_done;
    logic [akf_pkg::DIVD_W-1:0]  div_quot;
    logic                        q_clip;
    logic signed [31:0]          q_val;
    logic                        is_div;
    logic                        wr_en;
    logic [akf_pkg::ADDR_W-1:0]  wr_addr;
    logic [31:0]                 wr_data;
    logic                        wr_clip;
    logic                        accept;
    logic                        finish;
    logic                        jump_take;

    assign ctl       = akf_pkg::ucode(pc_reg);
    assign s_ready   = !busy_reg;
    assign cfg_ready = 1'b1;
    assign accept    = s_valid && !busy_reg;
    assign finish    = busy_reg && (ctl.op == akf_pkg::OP_DONE) && (!m_valid_reg || m_ready);
    assign is_div    = (ctl.op == akf_pkg::OP_MEAN) || (ctl.op == akf_pkg::OP_RECIP);

    // External operand words: registers, the measurement and constants.
    function automatic logic [31:0] ext_word(input logic [5:0] s);
        logic [31:0] w;
        case (s)
            akf_pkg::SRC_F00: w = cfg_reg[akf_pkg::CFG_F_ROW0][31:0];
            akf_pkg::SRC_F01: w = cfg_reg[akf_pkg::CFG_F_ROW0][63:32];
            akf_pkg::SRC_F10: w = cfg_reg[akf_pkg::CFG_F_ROW1][31:0];
            akf_pkg::SRC_F11: w = cfg_reg[akf_pkg::CFG_F_ROW1][63:32];
            akf_pkg::SRC_Q00: w = cfg_reg[akf_pkg::CFG_Q_ROW0][31:0];
            akf_pkg::SRC_Q01: w = cfg_reg[akf_pkg::CFG_Q_ROW0][63:32];
            akf_pkg::SRC_Q10: w = cfg_reg[akf_pkg::CFG_Q_ROW1][31:0];
            akf_pkg::SRC_Q11: w = cfg_reg[akf_pkg::CFG_Q_ROW1][63:32];
            akf_pkg::SRC_H0:  w = cfg_reg[akf_pkg::CFG_H_ROW][31:0];
            akf_pkg::SRC_H1:  w = cfg_reg[akf_pkg::CFG_H_ROW][63:32];
            akf_pkg::SRC_I0:  w = cfg_reg[akf_pkg::CFG_INIT][31:0];
            akf_pkg::SRC_I1:  w = cfg_reg[akf_pkg::CFG_INIT][63:32];
            akf_pkg::SRC_Z:   w = z_reg;
            akf_pkg::SRC_ONE: w = akf_pkg::ONE_Q16;
            default:          w = '0;
        endcase
        return w;
    endfunction

    always_comb begin
        case (ph_reg)
            PH0: begin
                src_a = ctl.a;
                src_b = ctl.b;
            end
            PH1: begin
                src_a = ctl.c;
                src_b = ctl.d;
            end
            PH2: begin
                src_a = ctl.e;
                src_b = akf_pkg::SRC_ZERO;
            end
            default: begin
                src_a = akf_pkg::SRC_ZERO;
                src_b = akf_pkg::SRC_ZERO;
            end
        endcase
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg[akf_pkg::CFG_F_ROW0] <= akf_pkg::F_ROW0_RESET;
            cfg_reg[akf_pkg::CFG_F_ROW1] <= akf_pkg::F_ROW1_RESET;
            cfg_reg[akf_pkg::CFG_Q_ROW0] <= '0;
            cfg_reg[akf_pkg::CFG_Q_ROW1] <= '0;
            cfg_reg[akf_pkg::CFG_H_ROW]  <= '0;
            cfg_reg[akf_pkg::CFG_INIT]   <= '0;
        end else if (cfg_valid && (cfg_index < 3'(akf_pkg::NUM_REGS))) begin
            cfg_reg[cfg_index] <= cfg_data;
        end
    end

    // Scratch memory: two registered read ports, one write port.
    always_ff @(posedge aclk) begin
        mem_qa_reg <= mem[src_a[akf_pkg::ADDR_W-1:0]];
        mem_qb_reg <= mem[src_b[akf_pkg::ADDR_W-1:0]];
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        vld_qa_reg <= vld_reg[src_a[akf_pkg::ADDR_W-1:0]];
        vld_qb_reg <= vld_reg[src_b[akf_pkg::ADDR_W-1:0]];
        sel_qa_reg <= src_a[akf_pkg::SRC_W-1];
        sel_qb_reg <= src_b[akf_pkg::SRC_W-1];
        ext_qa_reg <= ext_word(src_a);
        ext_qb_reg <= ext_word(src_b);
    end

    // Words never written since reset read as zero.
    assign opa = sel_qa_reg ? ext_qa_reg : (vld_qa_reg ? mem_qa_reg : '0);
    assign opb = sel_qb_reg ? ext_qb_reg : (vld_qb_reg ? mem_qb_reg : '0);

    // The mean update multiplies the count by the old mean square.
    always_comb begin
        mul_a = 33'(opa);
        mul_b = 33'(opb);
        if (ctl.op == akf_pkg::OP_MEAN) begin
            mul_a = {1'b0, count_reg};
            mul_b = {1'b0, opa};
        end
    end

    assign round_sum = acc_reg + 67'sd32768;
    assign t_sat     = akf_pkg::sat32(round_sum[66:16]);
    assign sum34     = ctl.sub ? (34'(e_reg) - 34'(t_reg)) : (34'(e_reg) + 34'(t_reg));
    assign y_sat     = akf_pkg::sat32(51'(sum34));
    assign y_val     = (ctl.clamp && y_sat.val[31]) ? '0 : y_sat.val;

    // Divider operands: the mean update and the reciprocal of S.
    assign cnt_p1 = {1'b0, count_reg} + 33'd1;
    always_comb begin
        if (ctl.op == akf_pkg::OP_MEAN) begin
            div_dividend = prod_reg[63:0] + {32'b0, e_reg} + {32'b0, cnt_p1[32:1]};
            div_divisor  = cnt_p1;
        end else begin
            div_dividend = 64'h0001_0000_0000_0000 + {33'b0, e_reg[31:1]};
            div_divisor  = {1'b0, e_reg};
        end
    end
    assign div_start = busy_reg && is_div && (ph_reg == PH2);
    assign q_clip    = (div_quot[63:31] != '0);
    assign q_val     = q_clip ? 32'h7FFF_FFFF : div_quot[31:0];

    akf_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_comb begin
        wr_en   = 1'b0;
        wr_data = y_val;
        wr_clip = y_sat.clip;
        if (busy_reg && (ctl.op == akf_pkg::OP_ARITH) && (ph_reg == PH5)) begin
            wr_en = 1'b1;
        end else if (busy_reg && is_div && (ph_reg == PH3) && div_done) begin
            wr_en   = 1'b1;
            wr_data = q_val;
            wr_clip = q_clip;
        end
    end
    assign wr_addr   = ctl.dest;
    assign jump_take = (ctl.cond == akf_pkg::COND_RESTART) ? restart_reg
                                                            : (opa[31] || (opa == '0));

    // Sequencer and state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            pc_reg      <= '0;
            ph_reg      <= PH0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
            vld_reg     <= '0;
        end else begin
            if (finish) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (wr_en) begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (accept) begin
                busy_reg <= 1'b1;
                pc_reg   <= '0;
                ph_reg   <= PH0;
            end else if (busy_reg) begin
                case (ctl.op)
                    akf_pkg::OP_ARITH: begin
                        if (ph_reg == PH5) begin
                            ph_reg <= PH0;
                            pc_reg <= pc_reg + 1'b1;
                        end else begin
                            ph_reg <= ph_reg + 3'd1;
                        end
                    end
                    akf_pkg::OP_MEAN, akf_pkg::OP_RECIP: begin
                        if (ph_reg == PH3) begin
                            if (div_done) begin
                                ph_reg <= PH0;
                                pc_reg <= pc_reg + 1'b1;
                            end
                        end else begin
                            ph_reg <= ph_reg + 3'd1;
                        end
                    end
                    akf_pkg::OP_JUMP: begin
                        if (ph_reg == PH1) begin
                            ph_reg <= PH0;
                            pc_reg <= jump_take ? ctl.target : pc_reg + 1'b1;
                        end else begin
                            ph_reg <= ph_reg + 3'd1;
                        end
                    end
                    akf_pkg::OP_DONE: begin
                        if (finish) begin
                            busy_reg <= 1'b0;
                            if (ctl.cnt == akf_pkg::CNT_INC) begin
                                if (count_reg != '1) begin
                                    count_reg <= count_reg + 1'b1;
                                end
                            end else if (ctl.cnt == akf_pkg::CNT_CLEAR) begin
                                count_reg <= '0;
                            end
                        end
                    end
                    default: begin
                        busy_reg <= 1'b0;
                    end
                endcase
            end
        end
    end

    // Datapath and result registers.
    always_ff @(posedge aclk) begin
        if (accept) begin
            restart_reg  <= s_restart;
            z_reg        <= s_measurement;
            wk_innov_reg <= '0;
            wk_noise_reg <= '0;
            wk_sing_reg  <= 1'b0;
            clip_reg     <= 1'b0;
        end else if (busy_reg) begin
            if (ph_reg == PH1 || ph_reg == PH2) begin
                prod_reg <= mul_a * mul_b;
            end
            if (ph_reg == PH2) begin
                acc_reg <= 67'(prod_reg);
            end
            if (ph_reg == PH3) begin
                acc_reg <= acc_reg + 67'(prod_reg);
            end
            if (ctl.op == akf_pkg::OP_ARITH && ph_reg == PH3) begin
                e_reg <= opa;
            end
            if (ph_reg == PH1 && ctl.op == akf_pkg::OP_MEAN) begin
                e_reg <= opb;
            end
            if (ph_reg == PH1 && ctl.op == akf_pkg::OP_RECIP) begin
                e_reg <= opa;
            end
            if (ctl.op == akf_pkg::OP_ARITH && ph_reg == PH4) begin
                t_reg <= t_sat.val;
                if (t_sat.clip) begin
                    clip_reg <= 1'b1;
                end
            end
            if (wr_en) begin
                if (wr_clip) begin
                    clip_reg <= 1'b1;
                end
                case (6'(wr_addr))
                    akf_pkg::M_X0: wk_est0_reg  <= wr_data;
                    akf_pkg::M_X1: wk_est1_reg  <= wr_data;
                    akf_pkg::M_V:  wk_innov_reg <= wr_data;
                    akf_pkg::M_R:  wk_noise_reg <= wr_data[30:0];
                    default: ;
                endcase
            end
            if (ctl.op == akf_pkg::OP_JUMP && ph_reg == PH1 &&
                ctl.cond == akf_pkg::COND_NOTPOS && jump_take) begin
                wk_sing_reg <= 1'b1;
            end
        end
        if (finish) begin
            out_est0_reg  <= wk_est0_reg;
            out_est1_reg  <= wk_est1_reg;
            out_innov_reg <= wk_innov_reg;
            out_noise_reg <= wk_noise_reg;
            out_sing_reg  <= wk_sing_reg;
            out_sat_reg   <= clip_reg;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_estimate_first  = out_est0_reg;
    assign m_estimate_second = out_est1_reg;
    assign m_innovation      = out_innov_reg;
    assign m_noise_estimate  = out_noise_reg;
    assign m_singular        = out_sing_reg;
    assign m_saturated       = out_sat_reg;

    `AKF_ASSERT_NXT(a_accept_busy, s_valid && s_ready, busy_reg)
    `AKF_ASSERT_IMP(a_no_write_idle, !busy_reg, !wr_en)
    `AKF_ASSERT_IMP(a_div_start_idle, div_start, !div_busy)
    `AKF_ASSERT_IMP(a_phase_range, busy_reg, ph_reg <= PH5)

endmodule
`default_nettype wire

### tb/adaptive_kalman_filter_step_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adaptive Kalman filter step testbench
// Drives restarts and measurements through the valid/ready input channel under
// several register settings, predicts results with a fixed-point filter model
// or a fixed table row, and checks each result item field by field in order.
// ----------------------------------------------------------------------------
module adaptive_kalman_filter_step_test;

    localparam logic [2:0] CFG_SPARE0 = 3'd6;
    localparam logic [2:0] CFG_SPARE1 = 3'd7;
    localparam logic signed [65:0] MAX32 = 66'sd2147483647;
    localparam logic signed [65:0] MIN32 = -66'sd2147483648;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 400;
    localparam int NUM_ROWS       = 22;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_ITEMS    = 104;

    typedef struct {
        logic signed [31:0] est0;
        logic signed [31:0] est1;
        logic signed [31:0] innov;
        logic [30:0]        noise;
        logic               singular;
        logic               saturated;
    } result_t;

    typedef struct {
        int                 setting;
        bit                 restart;
        logic signed [31:0] z;
        bit                 typed;
        result_t            res;
    } row_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic signed [31:0] s_measurement = '0;
    logic               s_restart = 1'b0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [31:0] m_estimate_first;
    logic signed [31:0] m_estimate_second;
    logic signed [31:0] m_innovation;
    logic [30:0]        m_noise_estimate;
    logic               m_singular;
    logic               m_saturated;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [2:0]         cfg_index = '0;
    logic [63:0]        cfg_data = '0;

    adaptive_kalman_filter_step dut (.*);

    always #6 aclk = ~aclk;

    // Filter state as the block should hold it.
    logic [63:0]        filter_regs [akf_pkg::NUM_REGS];
    logic signed [31:0] estimate [2];
    logic signed [31:0] covariance [4];
    logic [31:0]        mean_square;
    logic [31:0]        step_count;
    bit                 clipped;

    result_t expected_results [$];
    int      mismatches = 0;
    bit      no_idle = 1'b0;
    bit      done = 1'b0;
    int      quiet_cycles = 0;

    function automatic logic signed [31:0] sat(input logic signed [65:0] v);
        if (v > MAX32) begin
            clipped = 1'b1;
            return 32'sh7FFF_FFFF;
        end
        if (v < MIN32) begin
            clipped = 1'b1;
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] qdot(input logic signed [31:0] a0, b0, a1, b1);
        logic signed [65:0] ea0 = a0;
        logic signed [65:0] eb0 = b0;
        logic signed [65:0] ea1 = a1;
        logic signed [65:0] eb1 = b1;
        return sat((ea0 * eb0 + ea1 * eb1 + 66'sd32768) >>> 16);
    endfunction

    function automatic logic signed [31:0] qmul(input logic signed [31:0] a, b);
        return qdot(a, b, 32'sd0, 32'sd0);
    endfunction

    function automatic logic signed [31:0] addsub(input logic signed [31:0] a, b,
                                                  input bit neg);
        logic signed [65:0] ea = a;
        logic signed [65:0] eb = b;
        return sat(neg ? ea - eb : ea + eb);
    endfunction

    function automatic logic signed [31:0] reg_word(input int r, input int c);
        return filter_regs[r][32*c +: 32];
    endfunction

    function automatic result_t kalman_step(input bit restart, input logic signed [31:0] z);
        logic signed [31:0] f [2][2];
        logic signed [31:0] q [2][2];
        logic signed [31:0] h [2];
        logic signed [31:0] x1 [2];
        logic signed [31:0] fp [2][2];
        logic signed [31:0] pa [2][2];
        logic signed [31:0] pht [2];
        logic signed [31:0] k [2];
        logic signed [31:0] ikh [2][2];
        logic signed [31:0] v, vv, hx, hph, r, s, inv;
        longint unsigned    n, d, num, qt;
        result_t            res;
        clipped = 1'b0;
        res = '{default: '0};
        if (restart) begin
            estimate[0] = reg_word(akf_pkg::CFG_INIT, 0);
            estimate[1] = reg_word(akf_pkg::CFG_INIT, 1);
            step_count = '0;
            res.est0 = estimate[0];
            res.est1 = estimate[1];
            return res;
        end
        for (int i = 0; i < 2; i++) begin
            h[i] = reg_word(akf_pkg::CFG_H_ROW, i);
            for (int j = 0; j < 2; j++) begin
                f[i][j] = reg_word(akf_pkg::CFG_F_ROW0 + i, j);
                q[i][j] = reg_word(akf_pkg::CFG_Q_ROW0 + i, j);
            end
        end
        for (int i = 0; i < 2; i++) begin
            x1[i] = qdot(f[i][0], estimate[0], f[i][1], estimate[1]);
            for (int j = 0; j < 2; j++)
                fp[i][j] = qdot(f[i][0], covariance[j], f[i][1], covariance[2 + j]);
        end
        for (int i = 0; i < 2; i++)
            for (int j = 0; j < 2; j++)
                pa[i][j] = addsub(qdot(fp[i][0], f[j][0], fp[i][1], f[j][1]), q[i][j], 0);
        hx = qdot(h[0], x1[0], h[1], x1[1]);
        v  = addsub(z, hx, 1);
        vv = qmul(v, v);
        n = step_count;
        d = n + 1;
        num = n * longint'(mean_square) + longint'(32'(vv)) + d / 2;
        mean_square = 32'(num / d);
        for (int i = 0; i < 2; i++)
            pht[i] = qdot(pa[i][0], h[0], pa[i][1], h[1]);
        hph = qdot(h[0], pht[0], h[1], pht[1]);
        r = addsub($signed(mean_square), hph, 1);
        if (r < 0)
            r = '0;
        s = addsub(hph, r, 0);
        res.singular = (s <= 0);
        if (!res.singular) begin
            qt = ((64'd1 << 48) + longint'(s) / 2) / longint'(s);
            inv = sat($signed({2'b00, qt}));
            for (int i = 0; i < 2; i++) begin
                k[i] = qmul(pht[i], inv);
                estimate[i] = addsub(x1[i], qmul(k[i], v), 0);
            end
            for (int i = 0; i < 2; i++)
                for (int j = 0; j < 2; j++)
                    ikh[i][j] = addsub((i == j) ? akf_pkg::ONE_Q16 : 32'sd0,
                                       qmul(k[i], h[j]), 1);
            for (int i = 0; i < 2; i++)
                for (int j = 0; j < 2; j++)
                    covariance[i*2 + j] = qdot(ikh[i][0], pa[0][j], ikh[i][1], pa[1][j]);
            if (step_count != 32'hFFFF_FFFF)
                step_count++;
        end
        res.est0 = estimate[0];
        res.est1 = estimate[1];
        res.innov = v;
        res.noise = r[30:0];
        res.saturated = clipped;
        return res;
    endfunction

    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(0, 15);
    endfunction

    // Small signed value: offset plus a spread on either side.
    function automatic logic [31:0] near(input int centre, input int spread);
        return 32'(centre + $signed($urandom_range(0, 2 * spread)) - spread);
    endfunction

    function automatic logic [31:0] wild_word();
        case ($urandom_range(0, 3))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx < akf_pkg::NUM_REGS)
            filter_regs[idx] = value;
        @(posedge aclk);
    endtask

    task automatic send_item(input bit restart, input logic signed [31:0] z,
                             input bit typed, input result_t typed_res);
        int      gap;
        result_t res;
        gap = draw_gap();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_restart     <= restart;
        s_measurement <= z;
        do @(posedge aclk); while (!s_ready);
        res = kalman_step(restart, z);
        expected_results.push_back(typed ? typed_res : res);
    endtask

    // Stop offering items and wait until every result has come back.
    task automatic drain();
        s_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge aclk);
    endtask

    task automatic apply_setting(input int setting);
        case (setting)
            1: begin
                write_reg(akf_pkg::CFG_F_ROW0, {32'h0000_4000, 32'h0001_0000});
                write_reg(akf_pkg::CFG_F_ROW1, {32'h0000_F000, 32'h0000_0000});
                write_reg(akf_pkg::CFG_Q_ROW0, {32'h0000_0100, 32'h0000_2000});
                write_reg(akf_pkg::CFG_Q_ROW1, {32'h0000_2000, 32'h0000_0100});
                write_reg(akf_pkg::CFG_H_ROW,  {32'h0000_0000, 32'h0001_0000});
                write_reg(akf_pkg::CFG_INIT,   {32'hFFFE_0000, 32'h0003_0000});
                // Writes past the last register must leave everything alone.
                write_reg(CFG_SPARE0, 64'hFFFF_FFFF_FFFF_FFFF);
                write_reg(CFG_SPARE1, 64'h8000_0000_7FFF_FFFF);
            end
            2: begin
                write_reg(akf_pkg::CFG_F_ROW0, {32'h7FFF_FFFF, 32'h7FFF_FFFF});
                write_reg(akf_pkg::CFG_F_ROW1, {32'h8000_0000, 32'h7FFF_FFFF});
                write_reg(akf_pkg::CFG_Q_ROW0, {32'h8000_0000, 32'h7FFF_FFFF});
                write_reg(akf_pkg::CFG_Q_ROW1, {32'h7FFF_FFFF, 32'h8000_0000});
                write_reg(akf_pkg::CFG_H_ROW,  {32'h8000_0000, 32'h7FFF_FFFF});
                write_reg(akf_pkg::CFG_INIT,   {32'h8000_0000, 32'h7FFF_FFFF});
            end
            default: begin
            end
        endcase
    endtask

    task automatic random_setting();
        logic [31:0] w [12];
        bit          wild;
        wild = ($urandom_range(0, 4) == 0);
        w[0]  = near(32'h0001_0000, 32'h4000);
        w[1]  = near(0, 32'h4000);
        w[2]  = near(0, 32'h4000);
        w[3]  = near(32'h0001_0000, 32'h4000);
        w[4]  = $urandom_range(0, 32'h8000);
        w[5]  = near(0, 32'h400);
        w[6]  = w[5];
        w[7]  = $urandom_range(0, 32'h8000);
        w[8]  = ($urandom_range(0, 2) == 0) ? 32'h0 : near(32'h0001_0000, 32'h8000);
        w[9]  = ($urandom_range(0, 2) == 0) ? 32'h0 : near(0, 32'h8000);
        w[10] = near(0, 32'h40000);
        w[11] = near(0, 32'h40000);
        if (wild)
            for (int i = 0; i < 12; i++)
                if ($urandom_range(0, 2) == 0)
                    w[i] = wild_word();
        for (int i = 0; i < akf_pkg::NUM_REGS; i++)
            write_reg(3'(i), {w[2*i + 1], w[2*i]});
    endtask

    function automatic logic signed [31:0] random_measurement();
        case ($urandom_range(0, 15))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2, 3: return $urandom;
            default: return near(0, 32'h80000);
        endcase
    endfunction

    // Result side: random stalls, then compare with the oldest expectation.
    initial begin : result_check
        int      stall;
        result_t exp_res;
        wait (aresetn);
        forever begin
            stall = draw_gap();
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result item: est %h %h", m_estimate_first,
                             m_estimate_second);
            end else begin
                exp_res = expected_results.pop_front();
                if (m_estimate_first !== exp_res.est0 || m_estimate_second !== exp_res.est1
                    || m_innovation !== exp_res.innov || m_noise_estimate !== exp_res.noise
                    || m_singular !== exp_res.singular
                    || m_saturated !== exp_res.saturated) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp est %h %h v %h r %h sing %b sat %b, ",
                                  "got est %h %h v %h r %h sing %b sat %b"},
                                 exp_res.est0, exp_res.est1, exp_res.innov, exp_res.noise,
                                 exp_res.singular, exp_res.saturated, m_estimate_first,
                                 m_estimate_second, m_innovation, m_noise_estimate,
                                 m_singular, m_saturated);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready) || !aresetn)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT && !done) begin
            $display("adaptive_kalman_filter_step_test failed");
            $finish;
        end
    end

    initial begin : stimulus
        row_t    rows [NUM_ROWS];
        result_t none;
        int      setting;
        none = '{default: '0};
        rows = '{
            '{0, 1'b0, 32'sh0000_0000, 1'b1, '{0, 0, 0, 0, 1'b1, 1'b0}},
            '{0, 1'b1, 32'sh7FFF_FFFF, 1'b1, '{0, 0, 0, 0, 1'b0, 1'b0}},
            '{0, 1'b0, 32'sh0001_0000, 1'b0, none},
            '{0, 1'b0, 32'sh0000_0001, 1'b0, none},
            '{1, 1'b1, 32'sh8000_0000, 1'b1,
              '{32'sh0003_0000, 32'shFFFE_0000, 0, 0, 1'b0, 1'b0}},
            '{1, 1'b0, 32'sh0003_8000, 1'b0, none},
            '{1, 1'b0, 32'shFFFF_FFFF, 1'b0, none},
            '{1, 1'b0, 32'sh7FFF_FFFF, 1'b0, none},
            '{1, 1'b0, 32'sh8000_0000, 1'b0, none},
            '{1, 1'b0, 32'sh0000_0000, 1'b0, none},
            '{1, 1'b0, 32'sh0004_0000, 1'b0, none},
            '{1, 1'b1, 32'sh0000_0000, 1'b1,
              '{32'sh0003_0000, 32'shFFFE_0000, 0, 0, 1'b0, 1'b0}},
            '{1, 1'b0, 32'sh0002_0000, 1'b0, none},
            '{1, 1'b0, 32'shFFFD_0000, 1'b0, none},
            '{2, 1'b1, 32'sh1234_5678, 1'b1,
              '{32'sh7FFF_FFFF, 32'sh8000_0000, 0, 0, 1'b0, 1'b0}},
            '{2, 1'b0, 32'sh7FFF_FFFF, 1'b0, none},
            '{2, 1'b0, 32'sh8000_0000, 1'b0, none},
            '{2, 1'b0, 32'sh0000_0000, 1'b0, none},
            '{2, 1'b0, 32'shFFFF_FFFF, 1'b0, none},
            '{2, 1'b1, 32'sh0000_0000, 1'b1,
              '{32'sh7FFF_FFFF, 32'sh8000_0000, 0, 0, 1'b0, 1'b0}},
            '{2, 1'b0, 32'sh5555_5555, 1'b0, none},
            '{2, 1'b0, 32'shAAAA_AAAA, 1'b0, none}
        };

        filter_regs[akf_pkg::CFG_F_ROW0] = akf_pkg::F_ROW0_RESET;
        filter_regs[akf_pkg::CFG_F_ROW1] = akf_pkg::F_ROW1_RESET;
        for (int i = akf_pkg::CFG_Q_ROW0; i < akf_pkg::NUM_REGS; i++)
            filter_regs[i] = '0;
        for (int i = 0; i < 2; i++)
            estimate[i] = '0;
        for (int i = 0; i < 4; i++)
            covariance[i] = '0;
        mean_square = '0;
        step_count  = '0;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        setting = 0;
        foreach (rows[i]) begin
            if (rows[i].setting != setting) begin
                drain();
                setting = rows[i].setting;
                apply_setting(setting);
            end
            send_item(rows[i].restart, rows[i].z, rows[i].typed, rows[i].res);
        end

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            drain();
            no_idle = (p % 3 == 1);
            random_setting();
            // Start most phases from a known estimate so the filter can converge.
            if ($urandom_range(0, 3) != 0)
                send_item(1'b1, $urandom, 1'b0, none);
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_item($urandom_range(0, 11) == 0, random_measurement(), 1'b0, none);
        end

        drain();
        no_idle = 1'b0;
        repeat (SETTLE_CYCLES) @(posedge aclk);
        done = 1'b1;
        if (mismatches == 0 && expected_results.size() == 0)
            $display("adaptive_kalman_filter_step_test passed");
        else
            $display("adaptive_kalman_filter_step_test failed");
        $finish;
    end

endmodule

### adaptive_kalman_filter_step.f
+incdir+hw/rtl
hw/rtl/akf_pkg.sv
hw/rtl/akf_div.sv
hw/rtl/adaptive_kalman_filter_step.sv
tb/adaptive_kalman_filter_step_test.sv
